// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Include guarded; holds macro definitions only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on the rising edge, off while reset is high.
`define CHK_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("port check failed");

// Condition that must never be seen at a clock edge.
`define CHK_NEVER(label, clk, rst, expr) \
  `CHK_ASSERT(label, clk, rst, !(expr))

`endif

// ===== rtl/core/ledgsdc_pkg.sv =====
// Shared types, codes and the microcode table of the LED driver loader.
// No dependencies; imported by the sequencer, the buffers, the top level and the checker.
package ledgsdc_pkg;

  // Request codes.
  localparam logic [2:0] REQ_SET_GS    = 3'd0;
  localparam logic [2:0] REQ_ALL_GS    = 3'd1;
  localparam logic [2:0] REQ_SET_DC    = 3'd2;
  localparam logic [2:0] REQ_ALL_DC    = 3'd3;
  localparam logic [2:0] REQ_SEND_DC   = 3'd4;
  localparam logic [2:0] REQ_GS_UPDATE = 3'd5;
  localparam logic [2:0] REQ_TICK      = 3'd6;

  // Pin action codes.
  localparam logic [2:0] ACT_BLANK_HIGH = 3'd0;
  localparam logic [2:0] ACT_BLANK_LOW  = 3'd1;
  localparam logic [2:0] ACT_LATCH      = 3'd2;
  localparam logic [2:0] ACT_SCLK       = 3'd3;
  localparam logic [2:0] ACT_SHIFT      = 3'd4;

  // Emit conditions of a microcode step.
  localparam logic [2:0] COND_NONE   = 3'd0;
  localparam logic [2:0] COND_ALWAYS = 3'd1;
  localparam logic [2:0] COND_LATCH  = 3'd2;
  localparam logic [2:0] COND_SCLK   = 3'd3;
  localparam logic [2:0] COND_ARMED  = 3'd4;

  // How the last flag of an emitted result is formed.
  localparam logic [1:0] LAST_NO        = 2'd0;
  localparam logic [1:0] LAST_YES       = 2'd1;
  localparam logic [1:0] LAST_NOT_ARMED = 2'd2;
  localparam logic [1:0] LAST_BUF_END   = 2'd3;

  // Side effects on the mode and flag registers.
  localparam logic [2:0] FX_NONE       = 3'd0;
  localparam logic [2:0] FX_SAVE_PROG  = 3'd1;
  localparam logic [2:0] FX_TICK_LATCH = 3'd2;
  localparam logic [2:0] FX_GS_DONE    = 3'd3;
  localparam logic [2:0] FX_DC_MODE    = 3'd4;

  // Microcode addresses.
  localparam logic [3:0] STEP_IDLE     = 4'd0;
  localparam logic [3:0] STEP_BLANK_HI = 4'd1;
  localparam logic [3:0] STEP_T_LATCH  = 4'd2;
  localparam logic [3:0] STEP_T_SCLK   = 4'd3;
  localparam logic [3:0] STEP_BLANK_LO = 4'd4;
  localparam logic [3:0] STEP_GS_SHIFT = 4'd5;
  localparam logic [3:0] STEP_DC_MODE  = 4'd6;
  localparam logic [3:0] STEP_DC_SHIFT = 4'd7;
  localparam logic [3:0] STEP_DC_LATCH = 4'd8;

  typedef struct packed {
    logic [2:0] cond;
    logic [2:0] act;
    logic [1:0] last_sel;
    logic [2:0] fx;
    logic       dc_buf;
    logic       loop;
    logic [3:0] next;
  } uop_t;

  // Sequencer to datapath control for the current step.
  typedef struct packed {
    logic       fire;
    logic       emit;
    logic       done;
    logic [2:0] act;
    logic       last;
    logic [2:0] fx;
    logic       dc_buf;
    logic [1:0] phase;
  } ctl_t;

  typedef struct packed {
    logic latch_pending;
    logic sclk_due;
    logic update_armed;
  } flags_t;

  function automatic uop_t ucode_rom(input logic [3:0] addr);
    uop_t u;
    u = '{cond: COND_NONE, act: ACT_BLANK_HIGH, last_sel: LAST_NO, fx: FX_NONE,
          dc_buf: 1'b0, loop: 1'b0, next: STEP_IDLE};
    unique case (addr)
      STEP_BLANK_HI: begin
        u.cond = COND_ALWAYS; u.act = ACT_BLANK_HIGH; u.fx = FX_SAVE_PROG;
        u.next = STEP_T_LATCH;
      end
      STEP_T_LATCH: begin
        u.cond = COND_LATCH; u.act = ACT_LATCH; u.fx = FX_TICK_LATCH;
        u.next = STEP_T_SCLK;
      end
      STEP_T_SCLK: begin
        u.cond = COND_SCLK; u.act = ACT_SCLK; u.next = STEP_BLANK_LO;
      end
      STEP_BLANK_LO: begin
        u.cond = COND_ALWAYS; u.act = ACT_BLANK_LOW; u.last_sel = LAST_NOT_ARMED;
        u.next = STEP_GS_SHIFT;
      end
      STEP_GS_SHIFT: begin
        u.cond = COND_ARMED; u.act = ACT_SHIFT; u.last_sel = LAST_BUF_END;
        u.fx = FX_GS_DONE; u.loop = 1'b1; u.next = STEP_IDLE;
      end
      STEP_DC_MODE: begin
        u.fx = FX_DC_MODE; u.next = STEP_DC_SHIFT;
      end
      STEP_DC_SHIFT: begin
        u.cond = COND_ALWAYS; u.act = ACT_SHIFT; u.dc_buf = 1'b1; u.loop = 1'b1;
        u.next = STEP_DC_LATCH;
      end
      STEP_DC_LATCH: begin
        u.cond = COND_ALWAYS; u.act = ACT_LATCH; u.last_sel = LAST_YES;
        u.next = STEP_IDLE;
      end
      default: begin
        u.next = STEP_IDLE;
      end
    endcase
    return u;
  endfunction

  // Entry point of the program for a request; writes and arm requests stay idle.
  function automatic logic [3:0] dispatch(input logic [2:0] req_type);
    logic [3:0] s;
    unique case (req_type)
      REQ_SEND_DC: s = STEP_DC_MODE;
      REQ_TICK:    s = STEP_BLANK_HI;
      default:     s = STEP_IDLE;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/ledgsdc_req_if.sv =====
// Request channel of the LED driver loader: valid/ready plus request fields.
// Stand-alone; widths follow the request format.
interface ledgsdc_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [3:0]  channel;
  logic [11:0] value;

  modport source (output valid, output req_type, output channel, output value,
                  input ready);
  modport sink (input valid, input req_type, input channel, input value,
                output ready);
endinterface

// ===== rtl/core/ledgsdc_res_if.sv =====
// Result channel of the LED driver loader: valid/ready plus pin action fields.
// Stand-alone; widths follow the result format.
interface ledgsdc_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] shift_byte;
  logic       prog_mode_level;
  logic       dc_source_level;
  logic       last;

  modport source (output valid, output action, output shift_byte,
                  output prog_mode_level, output dc_source_level, output last,
                  input ready);
  modport sink (input valid, input action, input shift_byte,
                input prog_mode_level, input dc_source_level, input last,
                output ready);
endinterface

// ===== rtl/core/ledgsdc_seq.sv =====
// Microcoded sequencer: step counter, microcode table lookup and byte counter.
// Depends on ledgsdc_pkg for the table, codes and control structs.
module ledgsdc_seq #(
  parameter int NUM_DRIVERS = 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_fire,
  input  logic [2:0]                            req_type,
  input  ledgsdc_pkg::flags_t                   flags,
  input  logic                                  out_free,
  output ledgsdc_pkg::ctl_t                     ctl,
  output logic [$clog2(8*NUM_DRIVERS)-1:0]      rd_word,
  output logic                                  busy
);
  import ledgsdc_pkg::*;

  localparam int GW = $clog2(8*NUM_DRIVERS);
  localparam logic [GW-1:0] GS_LAST = GW'(8*NUM_DRIVERS-1);
  localparam logic [GW-1:0] DC_LAST = GW'(4*NUM_DRIVERS-1);

  logic [3:0]    step, step_next;
  logic [GW-1:0] word, word_next;
  logic [1:0]    phase, phase_next;
  uop_t          uop;
  logic          cond_true;
  logic          buf_end;
  logic          done;
  logic          fire;
  logic          last;

  always_comb begin
    uop = ucode_rom(step);
    unique case (uop.cond)
      COND_ALWAYS: cond_true = 1'b1;
      COND_LATCH:  cond_true = flags.latch_pending;
      COND_SCLK:   cond_true = flags.sclk_due;
      COND_ARMED:  cond_true = flags.update_armed;
      default:     cond_true = 1'b0;
    endcase
    buf_end = (phase == 2'd2) && (word == (uop.dc_buf ? DC_LAST : GS_LAST));
    // A looping step that emits stays put until the last byte of its buffer.
    done = !(uop.loop && cond_true) || buf_end;
    fire = (step != STEP_IDLE) && !(cond_true && !out_free);
    unique case (uop.last_sel)
      LAST_NO:        last = 1'b0;
      LAST_YES:       last = 1'b1;
      LAST_NOT_ARMED: last = !flags.update_armed;
      default:        last = buf_end;
    endcase

    step_next  = step;
    word_next  = word;
    phase_next = phase;
    if (step == STEP_IDLE) begin
      if (in_fire) begin
        step_next = dispatch(req_type);
      end
    end else if (fire) begin
      if (done) begin
        step_next  = uop.next;
        word_next  = '0;
        phase_next = 2'd0;
      end else if (phase == 2'd2) begin
        phase_next = 2'd0;
        word_next  = word + GW'(1);
      end else begin
        phase_next = phase + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= STEP_IDLE;
      word  <= '0;
      phase <= 2'd0;
    end else begin
      step  <= step_next;
      word  <= word_next;
      phase <= phase_next;
    end
  end

  assign ctl = '{fire: fire, emit: cond_true, done: done, act: uop.act, last: last,
                 fx: uop.fx, dc_buf: uop.dc_buf, phase: phase};
  assign rd_word = word;
  assign busy    = (step != STEP_IDLE);

endmodule

// ===== rtl/core/ledgsdc_buf.sv =====
// Grayscale and dot-correction shift buffers, kept as 24-bit packed words.
// Depends on ledgsdc_pkg for request codes.
module ledgsdc_buf #(
  parameter int NUM_DRIVERS = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              set_valid,
  input  logic [2:0]                        req_type,
  input  logic [3:0]                        channel,
  input  logic [11:0]                       value,
  input  logic                              rd_dc,
  input  logic [$clog2(8*NUM_DRIVERS)-1:0]  rd_word,
  input  logic [1:0]                        rd_phase,
  output logic [7:0]                        rd_byte
);
  import ledgsdc_pkg::*;

  localparam int GS_WORDS = 8*NUM_DRIVERS;
  localparam int DC_WORDS = 4*NUM_DRIVERS;
  localparam int GW = $clog2(GS_WORDS);
  localparam int DW = $clog2(DC_WORDS);
  localparam int CW = $clog2(16*NUM_DRIVERS);

  // Each GS word holds two channels and each DC word four, highest first,
  // so the three bytes of a word go out MSB first as the drivers expect.
  logic [23:0]   gs_word [GS_WORDS];
  logic [23:0]   dc_word [DC_WORDS];
  logic [CW-1:0] rc;
  logic [5:0]    dc_val;
  logic [23:0]   rd_data;

  assign rc     = CW'(16*NUM_DRIVERS-1) - CW'(channel);
  assign dc_val = value[5:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < GS_WORDS; i++) begin
        gs_word[i] <= '0;
      end
      for (int i = 0; i < DC_WORDS; i++) begin
        dc_word[i] <= '0;
      end
    end else if (set_valid) begin
      unique case (req_type)
        REQ_SET_GS: begin
          if (rc[0]) begin
            gs_word[rc[CW-1:1]][11:0] <= value;
          end else begin
            gs_word[rc[CW-1:1]][23:12] <= value;
          end
        end
        REQ_ALL_GS: begin
          for (int i = 0; i < GS_WORDS; i++) begin
            gs_word[i] <= {value, value};
          end
        end
        REQ_SET_DC: begin
          unique case (rc[1:0])
            2'd0: dc_word[rc[CW-1:2]][23:18] <= dc_val;
            2'd1: dc_word[rc[CW-1:2]][17:12] <= dc_val;
            2'd2: dc_word[rc[CW-1:2]][11:6]  <= dc_val;
            default: dc_word[rc[CW-1:2]][5:0] <= dc_val;
          endcase
        end
        REQ_ALL_DC: begin
          for (int i = 0; i < DC_WORDS; i++) begin
            dc_word[i] <= {dc_val, dc_val, dc_val, dc_val};
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rd_data = rd_dc ? dc_word[rd_word[DW-1:0]] : gs_word[rd_word[GW-1:0]];
    unique case (rd_phase)
      2'd0:    rd_byte = rd_data[23:16];
      2'd1:    rd_byte = rd_data[15:8];
      2'd2:    rd_byte = rd_data[7:0];
      default: rd_byte = 8'd0;
    endcase
  end

endmodule

// ===== rtl/core/led_driver_gs_dc_loader.sv =====
// Top level of the LED driver loader: mode flags, output register and glue.
// Depends on ledgsdc_pkg, both channel interfaces, ledgsdc_seq and ledgsdc_buf.
//
// Usage: each request on req sets grayscale or dot-correction data, arms a
// grayscale update, sends the dot-correction data or runs one PWM tick. Each
// action on the driver pins comes out on res as one result; last marks the
// final result of a request. Set and arm requests give no result.
// req.ready is high only while the sequencer is idle, so one request is in
// work at a time. The microcode sequencer puts out at most one pin action
// per cycle while the output register can take it; the shift steps read
// one byte per cycle from the buffers under the same condition.
// Results pass through a single output register; while res.ready is low the
// register holds and the sequencer waits on its next emitting step, so no
// result is lost. The next request may be accepted while the final result
// of the previous one still waits in that register.
// Reset (rst, synchronous) clears both buffers and the flags, raises the
// programming-mode line and leaves the output register empty.
module led_driver_gs_dc_loader #(
  parameter int NUM_DRIVERS = 1
) (
  input  logic          clk,
  input  logic          rst,
  ledgsdc_req_if.sink   req,
  ledgsdc_res_if.source res
);
  import ledgsdc_pkg::*;

  localparam int GW = $clog2(8*NUM_DRIVERS);

  logic          in_fire;
  logic          busy;
  logic          out_free;
  ctl_t          ctl;
  flags_t        flags;
  logic [GW-1:0] rd_word;
  logic [7:0]    rd_byte;

  logic latch_pending, latch_pending_next;
  logic update_armed, update_armed_next;
  logic prog_mode, prog_mode_next;
  logic dc_source, dc_source_next;
  logic sclk_due, sclk_due_next;
  logic out_valid;

  assign req.ready = !busy;
  assign in_fire   = req.valid && req.ready;
  assign out_free  = !out_valid || res.ready;
  assign flags     = '{latch_pending: latch_pending, sclk_due: sclk_due,
                       update_armed: update_armed};

  ledgsdc_seq #(.NUM_DRIVERS(NUM_DRIVERS)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .req_type (req.req_type),
    .flags    (flags),
    .out_free (out_free),
    .ctl      (ctl),
    .rd_word  (rd_word),
    .busy     (busy)
  );

  ledgsdc_buf #(.NUM_DRIVERS(NUM_DRIVERS)) u_buf (
    .clk       (clk),
    .rst       (rst),
    .set_valid (in_fire),
    .req_type  (req.req_type),
    .channel   (req.channel),
    .value     (req.value),
    .rd_dc     (ctl.dc_buf),
    .rd_word   (rd_word),
    .rd_phase  (ctl.phase),
    .rd_byte   (rd_byte)
  );

  always_comb begin
    latch_pending_next = latch_pending;
    update_armed_next  = update_armed;
    prog_mode_next     = prog_mode;
    dc_source_next     = dc_source;
    sclk_due_next      = sclk_due;
    if (in_fire && (req.req_type == REQ_GS_UPDATE)) begin
      update_armed_next = 1'b1;
    end
    if (ctl.fire) begin
      unique case (ctl.fx)
        FX_SAVE_PROG: sclk_due_next = prog_mode;
        FX_TICK_LATCH: begin
          prog_mode_next     = 1'b0;
          latch_pending_next = 1'b0;
        end
        FX_GS_DONE: begin
          // Only a tick that actually shifted grayscale data leaves a latch due.
          if (ctl.emit && ctl.done) begin
            latch_pending_next = 1'b1;
            update_armed_next  = 1'b0;
          end
        end
        FX_DC_MODE: begin
          prog_mode_next = 1'b1;
          dc_source_next = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latch_pending <= 1'b0;
      update_armed  <= 1'b0;
      prog_mode     <= 1'b1;
      dc_source     <= 1'b0;
      sclk_due      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      latch_pending <= latch_pending_next;
      update_armed  <= update_armed_next;
      prog_mode     <= prog_mode_next;
      dc_source     <= dc_source_next;
      sclk_due      <= sclk_due_next;
      if (ctl.fire && ctl.emit) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; the line levels reported are those after the action.
  always_ff @(posedge clk) begin
    if (ctl.fire && ctl.emit) begin
      res.action          <= ctl.act;
      res.shift_byte      <= (ctl.act == ACT_SHIFT) ? rd_byte : 8'd0;
      res.prog_mode_level <= prog_mode_next;
      res.dc_source_level <= dc_source_next;
      res.last            <= ctl.last;
    end
  end

  assign res.valid = out_valid;

endmodule

// ===== rtl/core/ledgsdc_chk.sv =====
// Port-level checker for the LED driver loader, bound to the top level.
// Depends on ledgsdc_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module ledgsdc_chk (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic [2:0] req_type,
  input logic       res_valid,
  input logic       res_ready,
  input logic [2:0] res_action,
  input logic [7:0] res_shift_byte,
  input logic       res_prog_mode_level,
  input logic       res_dc_source_level,
  input logic       res_last
);
  import ledgsdc_pkg::*;

  `CHK_ASSERT(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res_action) && $stable(res_shift_byte) && $stable(res_prog_mode_level) && $stable(res_dc_source_level) && $stable(res_last))
  `CHK_NEVER(a_byte_idle_zero, clk, rst, res_valid && (res_action != ACT_SHIFT) && (res_shift_byte != 8'd0))
  `CHK_NEVER(a_blank_low_prog, clk, rst, res_valid && (res_action == ACT_BLANK_LOW) && res_prog_mode_level)
  `CHK_NEVER(a_blank_high_last, clk, rst, res_valid && (res_action == ACT_BLANK_HIGH) && res_last)
  `CHK_ASSERT(a_tick_busy, clk, rst, req_valid && req_ready && (req_type == REQ_TICK) |=> !req_ready)

endmodule

bind led_driver_gs_dc_loader ledgsdc_chk u_chk (
  .clk                 (clk),
  .rst                 (rst),
  .req_valid           (req.valid),
  .req_ready           (req.ready),
  .req_type            (req.req_type),
  .res_valid           (res.valid),
  .res_ready           (res.ready),
  .res_action          (res.action),
  .res_shift_byte      (res.shift_byte),
  .res_prog_mode_level (res.prog_mode_level),
  .res_dc_source_level (res.dc_source_level),
  .res_last            (res.last)
);
